[rtl/wsd_pkg.sv]
package wsd_pkg;

   localparam int OP_WIDTH     = 1;
   localparam int THREAD_WIDTH = 3;
   localparam int FIELD_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 3;

   localparam int MAX_ACTIVE = 8;

   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [THREAD_WIDTH-1:0] thread_type;
   typedef logic [FIELD_WIDTH-1:0]  field_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [THREAD_WIDTH:0]   total_type;

   localparam op_type OP_PUSH = 1'b0;
   localparam op_type OP_TAKE = 1'b1;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_DROPPED = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;

   localparam count_type WORKERS_RESET = 3'd1;

endpackage

[rtl/work_stealing_deque_scheduler.sv]
// Each request beat has two steps: the decision and the slot memory access, then the
// registered read data. A new request beat is taken only after the previous one has
// moved on to the response register. The response is registered; a response that waits
// lets one more beat be taken and held, after which requests stall until it is taken.
// Synchronous active-high reset empties every deque and sets the worker count to one.
// The slot memory is not cleared; only occupied slots are ever read.
module work_stealing_deque_scheduler #(
   parameter int MAX_DEQUES  = 8,
   parameter int DEQUE_DEPTH = 64,
   parameter int JOB_WIDTH   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wsd_pkg::op_type     req_operation,
   input  wsd_pkg::thread_type req_thread_index,
   input  wsd_pkg::field_type  req_job_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wsd_pkg::status_type rsp_status,
   output wsd_pkg::field_type  rsp_job_out,
   output wsd_pkg::thread_type rsp_source_deque,
   output logic                rsp_was_stolen,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  wsd_pkg::count_type  csr_worker_count
);
   import wsd_pkg::*;

   localparam int DW    = (MAX_DEQUES > 1) ? $clog2(MAX_DEQUES) : 1;
   localparam int SW    = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
   localparam int PW    = $clog2(2 * DEQUE_DEPTH);
   localparam int AW    = $clog2(MAX_DEQUES * DEQUE_DEPTH);
   localparam int SLOTS = MAX_DEQUES * DEQUE_DEPTH;
   localparam int CAP   = (MAX_DEQUES < MAX_ACTIVE) ? MAX_DEQUES : MAX_ACTIVE;

   typedef logic [PW-1:0] ptr_type;

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_inc = (p == PW'(2 * DEQUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_dec = (p == '0) ? PW'(2 * DEQUE_DEPTH - 1) : p - PW'(1);
   endfunction

   function automatic logic [SW-1:0] ptr_slot(input ptr_type p);
      logic [PW-1:0] s;
      s = (p >= PW'(DEQUE_DEPTH)) ? p - PW'(DEQUE_DEPTH) : p;
      ptr_slot = SW'(s);
   endfunction

   function automatic logic [PW:0] occupancy(input ptr_type b, input ptr_type t);
      occupancy = (b >= t) ? {1'b0, b} - {1'b0, t}
                           : {1'b0, b} + (PW + 1)'(2 * DEQUE_DEPTH) - {1'b0, t};
   endfunction

   count_type worker_count_ff;
   ptr_type   top_ff [MAX_DEQUES];
   ptr_type   bot_ff [MAX_DEQUES];

   logic [JOB_WIDTH-1:0] slot_mem [SLOTS];
   logic [JOB_WIDTH-1:0] rd_data_ff;

   logic       pend_ff;
   status_type pend_status_ff;
   logic       pend_ok_ff;
   thread_type pend_source_ff;
   logic       pend_stolen_ff;

   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   field_type  rsp_job_ff;
   thread_type rsp_source_ff;
   logic       rsp_stolen_ff;

   total_type       total;
   total_type       sum;
   total_type       tid_wide;
   total_type       cand;
   total_type       vic;
   logic            vic_found;
   logic [DW-1:0]   own;
   logic [DW-1:0]   vic_d;
   logic            tid_ok;
   logic            own_nonempty;
   logic            own_full;
   logic            accept;
   logic            move_out;
   logic            do_push;
   logic            do_pop;
   logic            do_steal;
   logic [DW-1:0]   mem_deque;
   logic [SW-1:0]   mem_slot;
   logic [AW-1:0]   mem_addr;
   status_type      new_status;
   thread_type      new_source;

   assign sum      = {1'b0, worker_count_ff} + total_type'(1);
   assign total    = (sum > total_type'(CAP)) ? total_type'(CAP) : sum;
   assign tid_wide = {1'b0, req_thread_index};
   assign tid_ok   = tid_wide < total;
   assign own      = DW'(req_thread_index);

   assign own_nonempty = top_ff[own] != bot_ff[own];
   assign own_full     = occupancy(bot_ff[own], top_ff[own]) >= (PW + 1)'(DEQUE_DEPTH);

   always_comb begin
      vic_found = 1'b0;
      vic       = '0;
      cand      = (tid_wide + total_type'(1) >= total) ? '0 : tid_wide + total_type'(1);
      for (int i = 0; i < CAP - 1; i++) begin
         if (!vic_found && (total_type'(i + 1) < total) &&
             (top_ff[DW'(cand)] != bot_ff[DW'(cand)])) begin
            vic_found = 1'b1;
            vic       = cand;
         end
         cand = (cand + total_type'(1) >= total) ? '0 : cand + total_type'(1);
      end
   end

   assign vic_d = DW'(vic);

   assign req_ready = !pend_ff && !reset;
   assign accept    = req_valid && req_ready;
   assign move_out  = pend_ff && (!rsp_valid_ff || rsp_ready);

   assign do_push  = accept && (req_operation == OP_PUSH) && tid_ok && !own_full;
   assign do_pop   = accept && (req_operation == OP_TAKE) && tid_ok && own_nonempty;
   assign do_steal = accept && (req_operation == OP_TAKE) && tid_ok && !own_nonempty &&
                     vic_found;

   always_comb begin
      if (do_steal) begin
         mem_deque = vic_d;
         mem_slot  = ptr_slot(top_ff[vic_d]);
      end else if (do_pop) begin
         mem_deque = own;
         mem_slot  = ptr_slot(ptr_dec(bot_ff[own]));
      end else begin
         mem_deque = own;
         mem_slot  = ptr_slot(bot_ff[own]);
      end
   end

   assign mem_addr = AW'(mem_deque) * AW'(DEQUE_DEPTH) + AW'(mem_slot);

   always_comb begin
      new_source = '0;
      if (req_operation == OP_PUSH) begin
         new_status = do_push ? ST_DONE : ST_DROPPED;
      end else if (do_pop) begin
         new_status = ST_DONE;
         new_source = req_thread_index;
      end else if (do_steal) begin
         new_status = ST_DONE;
         new_source = vic[THREAD_WIDTH-1:0];
      end else begin
         new_status = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_mem[mem_addr] <= JOB_WIDTH'(req_job_id);
      end
      if (do_pop || do_steal) begin
         rd_data_ff <= slot_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DEQUES; d++) begin
            top_ff[d] <= '0;
            bot_ff[d] <= '0;
         end
      end else begin
         if (do_push) begin
            bot_ff[own] <= ptr_inc(bot_ff[own]);
         end
         if (do_pop) begin
            bot_ff[own] <= ptr_dec(bot_ff[own]);
         end
         if (do_steal) begin
            top_ff[vic_d] <= ptr_inc(top_ff[vic_d]);
         end
      end
   end

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WORKERS_RESET;
      end else if (csr_valid && csr_ready) begin
         worker_count_ff <= csr_worker_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (accept) begin
         pend_ff <= 1'b1;
      end else if (move_out) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= new_status;
         pend_ok_ff     <= do_pop || do_steal;
         pend_source_ff <= new_source;
         pend_stolen_ff <= do_steal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         rsp_status_ff <= pend_status_ff;
         rsp_job_ff    <= pend_ok_ff ? FIELD_WIDTH'(rd_data_ff) : '0;
         rsp_source_ff <= pend_source_ff;
         rsp_stolen_ff <= pend_stolen_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_job_out      = rsp_job_ff;
   assign rsp_source_deque = rsp_source_ff;
   assign rsp_was_stolen   = rsp_stolen_ff;

endmodule

[tb/work_stealing_deque_scheduler_tb.sv]
`timescale 1ns / 100ps

module work_stealing_deque_scheduler_tb;
   import wsd_pkg::*;

   localparam int JOB_DEPTH    = 64;
   localparam int PTR_WIDTH    = 7;
   localparam int RANDOM_ITEMS = 550;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 250;

   typedef logic [PTR_WIDTH-1:0] ptr_type;

   typedef struct packed {
      status_type status;
      field_type  job;
      thread_type origin;
      logic       stolen;
   } outcome_type;

   // Mirror of every deque and the worker count; each accepted request beat
   // yields one expected response beat.
   class deque_tracker;
      field_type   slots [MAX_ACTIVE*JOB_DEPTH];
      ptr_type     top_ptr [MAX_ACTIVE];
      ptr_type     bottom_ptr [MAX_ACTIVE];
      count_type   workers;
      outcome_type outcomes_due [$];
      int          errors;

      function new();
         workers = WORKERS_RESET;
         errors = 0;
         foreach (top_ptr[d]) begin
            top_ptr[d] = '0;
            bottom_ptr[d] = '0;
         end
      endfunction

      function int active_deques();
         int total;
         total = int'(workers) + 1;
         if (total > MAX_ACTIVE)
            total = MAX_ACTIVE;
         return total;
      endfunction

      function ptr_type fill_level(int d);
         return bottom_ptr[d] - top_ptr[d];
      endfunction

      function void set_workers(count_type value);
         workers = value;
      endfunction

      function void apply_request(op_type op, thread_type tid, field_type job);
         outcome_type res;
         int total;
         int victim;
         res.status = ST_EMPTY;
         res.job = '0;
         res.origin = '0;
         res.stolen = 1'b0;
         total = active_deques();
         if (op == OP_PUSH) begin
            if (int'(tid) >= total || fill_level(tid) >= JOB_DEPTH) begin
               res.status = ST_DROPPED;
            end else begin
               slots[tid*JOB_DEPTH + bottom_ptr[tid] % JOB_DEPTH] = job;
               bottom_ptr[tid] = bottom_ptr[tid] + 1'b1;
               res.status = ST_DONE;
            end
         end else if (int'(tid) < total) begin
            if (fill_level(tid) != 0) begin
               bottom_ptr[tid] = bottom_ptr[tid] - 1'b1;
               res.job = slots[tid*JOB_DEPTH + bottom_ptr[tid] % JOB_DEPTH];
               res.origin = tid;
               res.status = ST_DONE;
            end else begin
               for (int i = 0; i + 1 < total; i++) begin
                  victim = (int'(tid) + 1 + i) % total;
                  if (res.status == ST_EMPTY && fill_level(victim) != 0) begin
                     res.job = slots[victim*JOB_DEPTH + top_ptr[victim] % JOB_DEPTH];
                     top_ptr[victim] = top_ptr[victim] + 1'b1;
                     res.origin = thread_type'(victim);
                     res.stolen = 1'b1;
                     res.status = ST_DONE;
                  end
               end
            end
         end
         outcomes_due = {outcomes_due, res};
      endfunction

      function void report_field(string field, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, seen);
            errors++;
         end
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (outcomes_due.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d job %h",
                     $time, got.status, got.job);
            errors++;
            return;
         end
         want = outcomes_due.pop_front();
         report_field("status", 32'(want.status), 32'(got.status));
         report_field("job_out", want.job, got.job);
         report_field("source_deque", 32'(want.origin), 32'(got.origin));
         report_field("was_stolen", 32'(want.stolen), 32'(got.stolen));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   op_type     req_operation = OP_PUSH;
   thread_type req_thread_index = '0;
   field_type  req_job_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   status_type rsp_status;
   field_type  rsp_job_out;
   thread_type rsp_source_deque;
   logic       rsp_was_stolen;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   count_type  csr_worker_count = '0;

   deque_tracker tracker = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;

   work_stealing_deque_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_thread_index (req_thread_index),
      .req_job_id       (req_job_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_job_out      (rsp_job_out),
      .rsp_source_deque (rsp_source_deque),
      .rsp_was_stolen   (rsp_was_stolen),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_worker_count (csr_worker_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.set_workers(csr_worker_count);
         if (rsp_valid && rsp_ready)
            tracker.check_outcome({rsp_status, rsp_job_out, rsp_source_deque, rsp_was_stolen});
         if (req_valid && req_ready)
            tracker.apply_request(req_operation, req_thread_index, req_job_id);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(input op_type op, input thread_type tid, input field_type job);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_thread_index <= tid;
      req_job_id <= job;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
   endtask

   task automatic write_workers(input count_type value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outcomes_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_worker_count <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic thread_type pick_active();
      return thread_type'($urandom_range(0, tracker.active_deques() - 1));
   endfunction

   task automatic run_segment(input bit fill_first);
      int kind;
      int count;
      thread_type tid;
      kind = fill_first ? 0 : $urandom_range(0, 9);
      if (kind == 0) begin
         tid = pick_active();
         repeat (JOB_DEPTH + 2) send_request(OP_PUSH, tid, $urandom);
         repeat ($urandom_range(1, JOB_DEPTH)) send_request(OP_TAKE, pick_active(), $urandom);
      end else if (kind <= 6) begin
         count = $urandom_range(1, 12);
         repeat (count) send_request(OP_PUSH, pick_active(), $urandom);
         repeat (count + $urandom_range(0, 3))
            send_request(OP_TAKE, pick_active(), $urandom);
      end else begin
         repeat (8)
            send_request(op_type'($urandom_range(0, 1)), thread_type'($urandom_range(0, 7)),
                         $urandom);
      end
   endtask

   initial begin
      int target;
      count_type value;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two deques are active after reset.
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);
      send_request(OP_PUSH, 3'd0, 32'h0000_0000);
      send_request(OP_PUSH, 3'd0, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 3'd1, 32'hA5A5_A5A5);
      send_request(OP_TAKE, 3'd0, 32'hFFFF_FFFF);
      send_request(OP_TAKE, 3'd1, 32'h0000_0000);
      send_request(OP_TAKE, 3'd1, 32'h1234_5678);
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);
      send_request(OP_PUSH, 3'd7, 32'h5A5A_5A5A);
      send_request(OP_TAKE, 3'd7, 32'h0000_0000);
      send_request(OP_PUSH, 3'd2, 32'h0000_0001);
      write_workers(3'd7);
      send_request(OP_PUSH, 3'd7, 32'h1234_5678);
      send_request(OP_PUSH, 3'd3, 32'h8000_0001);
      send_request(OP_TAKE, 3'd6, 32'h0000_0000);
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);
      send_request(OP_PUSH, 3'd5, 32'h7FFF_FFFE);
      // With no workers only the main deque is active; deque five keeps its job.
      write_workers(3'd0);
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);
      send_request(OP_PUSH, 3'd5, 32'hCAFE_F00D);
      send_request(OP_PUSH, 3'd0, 32'hDEAD_BEEF);
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);
      write_workers(3'd7);
      send_request(OP_TAKE, 3'd0, 32'h0000_0000);

      target = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 14 : 0;
         target += RANDOM_ITEMS / 3;
         if (phase == 2)
            hold_request = 1'b1;
         run_segment(phase == 0);
         while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 2) == 0)
                  value = $urandom_range(0, 1) ? 3'd7 : 3'd0;
               else
                  value = count_type'($urandom_range(0, 7));
               write_workers(value);
            end
            run_segment(1'b0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outcomes_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
rtl/wsd_pkg.sv
rtl/work_stealing_deque_scheduler.sv
tb/work_stealing_deque_scheduler_tb.sv
